>>> rtl/core/bqdd_pkg.sv
// ----------------------------------------------------------------------------
// bqdd_pkg
// Shared types and constants for the byte queue with delimiter discard:
// word layouts, operation codes, controller states and the control bundles.
// ----------------------------------------------------------------------------
package bqdd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned FILL_W = 6;

    localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

    typedef enum logic [1:0] {
        KIND_APPEND  = 2'd0,
        KIND_POP     = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_DISCARD = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] delimiter;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] popped_byte;
        logic [BYTE_W-1:0] head_byte;
        logic [FILL_W-1:0] fill_count;
        logic              append_dropped;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_CAP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_HEAD_RD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic append;
        logic pop_read;
        logic pop_take;
        logic clear;
        logic scan_start;
        logic scan_read;
        logic scan_next;
        logic scan_take;
        logic head_read;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  refused;
        logic  count_zero;
        logic  scan_hit;
        logic  scan_last;
        logic  out_free;
    } dp_status_t;

endpackage

>>> rtl/core/bqdd_ctrl.sv
// ----------------------------------------------------------------------------
// bqdd_ctrl
// Controller state machine: sequences one operation at a time through the
// datapath and its byte store, which has a single read port.
// ----------------------------------------------------------------------------
module bqdd_ctrl
    import bqdd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.kind)
                    KIND_POP:
                    begin
                        state_next = status.count_zero ? ST_HEAD_RD : ST_POP_CAP;
                    end
                    KIND_DISCARD:
                    begin
                        state_next = status.count_zero ? ST_HEAD_RD : ST_SCAN_RD;
                    end
                    default:
                    begin
                        state_next = ST_HEAD_RD;
                    end
                endcase
            end
            ST_POP_CAP:
            begin
                state_next = ST_HEAD_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (status.scan_hit || status.scan_last)
                begin
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_HEAD_RD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            ST_EXEC:
            begin
                unique case (status.kind)
                    KIND_APPEND:
                    begin
                        cmd.append = 1'b1;
                    end
                    KIND_POP:
                    begin
                        cmd.pop_read = !status.count_zero;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    default:
                    begin
                        // an empty queue has nothing to scan
                        cmd.clear      = status.count_zero;
                        cmd.scan_start = !status.count_zero;
                    end
                endcase
            end
            ST_POP_CAP:
            begin
                cmd.pop_take = 1'b1;
            end
            ST_SCAN_RD:
            begin
                cmd.scan_read = 1'b1;
            end
            ST_SCAN_CMP:
            begin
                // match on the last byte, or no match at all, empties the queue
                if (status.scan_last)
                begin
                    cmd.clear = 1'b1;
                end
                else if (status.scan_hit)
                begin
                    cmd.scan_take = 1'b1;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_HEAD_RD:
            begin
                cmd.head_read = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/bqdd_datapath.sv
// ----------------------------------------------------------------------------
// bqdd_datapath
// Byte store, head and count registers, delimiter scan pointer and the
// output word register.
// ----------------------------------------------------------------------------
module bqdd_datapath
    import bqdd_pkg::*;
#(
    parameter int unsigned DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_item,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  logic       out_ready,
    output logic       out_valid,
    output out_item_t  out_item
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [IW-1:0]     head_reg;
    logic [IW-1:0]     head_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    kind_t             kind_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] delim_reg;
    logic [BYTE_W-1:0] popped_reg;
    logic              dropped_reg;
    logic [IW-1:0]     scan_addr_reg;
    logic [CW-1:0]     scan_cnt_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    out_item_t         out_reg;

    logic [SW-1:0]     tail_sum;
    logic [IW-1:0]     tail_addr;
    logic [IW-1:0]     rd_addr;
    logic              rd_en;
    logic              wr_en;
    logic              refused;
    logic              count_zero;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
        logic [IW-1:0] r;
        r = (a == IW'(DEPTH - 1)) ? '0 : a + 1'b1;
        return r;
    endfunction

    assign count_zero = (count_reg == '0);
    assign refused    = (data_reg == NUL_BYTE) || (count_reg == CW'(DEPTH));
    assign wr_en      = cmd.append && !refused;

    // tail position: head + count stays below twice the depth
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_addr = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH))
                                                : IW'(tail_sum);

    assign rd_en   = cmd.pop_read || cmd.head_read || cmd.scan_read;
    assign rd_addr = cmd.scan_read ? scan_addr_reg : head_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_addr] <= data_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop_take)
        begin
            count_next = count_reg - 1'b1;
            head_next  = (count_reg == CW'(1)) ? '0 : wrap_inc(head_reg);
        end
        else if (cmd.scan_take)
        begin
            // drop everything through the matched byte
            count_next = count_reg - scan_cnt_reg - 1'b1;
            head_next  = wrap_inc(scan_addr_reg);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg    <= in_item.kind;
            data_reg    <= in_item.data_byte;
            delim_reg   <= in_item.delimiter;
            popped_reg  <= NUL_BYTE;
            dropped_reg <= 1'b0;
        end
        if (cmd.append)
        begin
            dropped_reg <= refused;
        end
        if (cmd.pop_take)
        begin
            popped_reg <= rd_data_reg;
        end
        if (cmd.scan_start)
        begin
            scan_addr_reg <= head_reg;
            scan_cnt_reg  <= '0;
        end
        else if (cmd.scan_next)
        begin
            scan_addr_reg <= wrap_inc(scan_addr_reg);
            scan_cnt_reg  <= scan_cnt_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            out_reg.popped_byte    <= popped_reg;
            out_reg.head_byte      <= count_zero ? NUL_BYTE : rd_data_reg;
            out_reg.fill_count     <= FILL_W'(count_reg);
            out_reg.append_dropped <= dropped_reg;
        end
    end

    assign status.kind       = kind_reg;
    assign status.refused    = refused;
    assign status.count_zero = count_zero;
    assign status.scan_hit   = (rd_data_reg == delim_reg);
    assign status.scan_last  = (scan_cnt_reg == count_reg - 1'b1);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

>>> rtl/core/byte_queue_with_delimiter_discard_unit.sv
// ----------------------------------------------------------------------------
// byte_queue_with_delimiter_discard_unit
// Queue of nonzero bytes with append, pop, clear and discard-through-delimiter.
// ----------------------------------------------------------------------------
// One word is taken at a time and each gives exactly one result word. Every
// operation ends with a head lookup in the byte store; pop first reads the
// popped byte, and discard first reads and compares each byte up to the
// match (at most DEPTH bytes), as the lookup and the scan share the single
// read port of the store. A finished result sits in an output register, so
// the next word is taken while it waits; only the next result stalls behind it.
module byte_queue_with_delimiter_discard_unit
    import bqdd_pkg::*;
#(
    parameter int unsigned DEPTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bqdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bqdd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

>>> rtl/core/bqdd_checker.sv
// ----------------------------------------------------------------------------
// bqdd_checker
// Port-level checks on the result words of the byte queue.
// ----------------------------------------------------------------------------
module bqdd_checker
    import bqdd_pkg::*;
#(
    parameter int unsigned DEPTH = 32
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // one word at a time: input closes right after a word is taken
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after a word was taken");

    // a held result word keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result word changed while stalled");

    // count never exceeds capacity (only checkable while it fits the field)
    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 63) || (out_item.fill_count <= FILL_W'(DEPTH)))
        else $error("fill count above capacity");

    // stored bytes are never zero, so a zero head means an empty queue
    a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.head_byte == NUL_BYTE) |-> (out_item.fill_count == '0))
        else $error("zero head byte with bytes stored");

    // a refused append never pops anything
    a_drop_nopop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.append_dropped |-> (out_item.popped_byte == NUL_BYTE))
        else $error("dropped append with popped byte");

endmodule

bind byte_queue_with_delimiter_discard_unit bqdd_checker #(
    .DEPTH (DEPTH)
) u_bqdd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
